[rtl/core/nbev_pkg.sv]
// Package for the noise burst envelope VCA: configuration register indexes,
// reset values, opcode codes and the configuration and result-flag structs.
// Used by nbev_env and noise_burst_envelope_vca; depends on nothing.
package nbev_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int COEF_W      = 17;
   localparam int COEF_FRAC   = 16;
   localparam int COUNT_W     = 10;
   localparam int START_AMP_W = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_ENABLE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_COEF          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_COEF           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_LENGTH         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENVELOPE_LENGTH     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRIGGER_AMPLITUDE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRESH_AMPLITUDE     = 3'd6;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_TRIGGER = 1'b1;

   localparam logic [COEF_W-1:0]      RST_DECAY_COEF          = 17'd64881;
   localparam logic [COEF_W-1:0]      RST_RISE_COEF           = 17'd66198;
   localparam logic [COUNT_W-1:0]     RST_RISE_LENGTH         = 10'd140;
   localparam logic [COUNT_W-1:0]     RST_ENVELOPE_LENGTH     = 10'd600;
   localparam logic [START_AMP_W-1:0] RST_RETRIGGER_AMPLITUDE = 24'd335544;
   localparam logic [START_AMP_W-1:0] RST_FRESH_AMPLITUDE     = 24'd503316;

   typedef struct packed {
      logic                   decay_enable;
      logic [COEF_W-1:0]      decay_coef;
      logic [COEF_W-1:0]      rise_coef;
      logic [COUNT_W-1:0]     rise_length;
      logic [COUNT_W-1:0]     envelope_length;
      logic [START_AMP_W-1:0] retrigger_amplitude;
      logic [START_AMP_W-1:0] fresh_amplitude;
   } nbev_cfg_type;

   typedef struct packed {
      logic idle_flag;
      logic is_trigger_reply;
   } nbev_flags_type;

endpackage

[rtl/core/nbev_env.sv]
// Envelope state and arithmetic: holds count, amplitude and idle, scales a
// sample by the held amplitude and advances the envelope on each step.
// Depends on nbev_pkg.
module nbev_env #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int AMP_FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     opcode,
   input  logic [SAMPLE_WIDTH-1:0]  sample_in,
   input  nbev_pkg::nbev_cfg_type   cfg,
   output logic [SAMPLE_WIDTH-1:0]  sample_out,
   output nbev_pkg::nbev_flags_type flags
);
   import nbev_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int AF     = AMP_FRAC_BITS;
   localparam int ScaleW = AF + COEF_W + 1;
   localparam int StartW = (AF > START_AMP_W) ? AF : START_AMP_W;
   localparam logic [ScaleW-1:0]   ScaleRound = ScaleW'(1) << (COEF_FRAC - 1);
   localparam logic [SW+AF:0]      VcaRound   = (SW + AF + 1)'(1) << (AF - 1);
   localparam logic [AF-1:0]       AmpMax     = {AF{1'b1}};

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [AF-1:0]      amp_ff, amp_in;
   logic               idle_ff, idle_in;

   logic               in_rise;
   logic [COEF_W-1:0]  coef_sel;
   logic [ScaleW-1:0]  scale_full;
   logic [AF+1:0]      scale_shift;
   logic [AF-1:0]      amp_scaled;
   logic [StartW-1:0]  start_ext;
   logic [AF-1:0]      start_amp;
   logic signed [SW+AF:0] vca_prod;
   logic signed [SW+AF:0] vca_sum;
   logic [SW:0]        vca_shift;
   logic [SW-1:0]      vca_out;

   always_comb begin
      in_rise     = count_ff < cfg.rise_length;
      coef_sel    = in_rise ? cfg.rise_coef : cfg.decay_coef;
      scale_full  = ScaleW'(amp_ff) * ScaleW'(coef_sel) + ScaleRound;
      scale_shift = scale_full[ScaleW-1:COEF_FRAC];
      amp_scaled  = (|scale_shift[AF+1:AF]) ? AmpMax : scale_shift[AF-1:0];

      start_ext = StartW'((count_ff > cfg.rise_length) ? cfg.retrigger_amplitude
                                                       : cfg.fresh_amplitude);
      start_amp = (start_ext > StartW'(AmpMax)) ? AmpMax : start_ext[AF-1:0];

      vca_prod  = $signed(sample_in) * $signed({1'b0, amp_ff});
      vca_sum   = vca_prod + $signed(VcaRound);
      vca_shift = vca_sum[SW+AF:AF];
      if (vca_shift[SW] != vca_shift[SW-1]) begin
         vca_out = {vca_shift[SW], {(SW-1){~vca_shift[SW]}}};
      end else begin
         vca_out = vca_shift[SW-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      amp_in   = amp_ff;
      idle_in  = idle_ff;
      unique case (opcode)
         OP_TRIGGER: begin
            count_in = '0;
            amp_in   = start_amp;
         end
         OP_SAMPLE: begin
            if (in_rise) begin
               count_in = count_ff + COUNT_W'(1);
               idle_in  = 1'b0;
               amp_in   = amp_scaled;
            end else begin
               if (count_ff < cfg.envelope_length) begin
                  count_in = count_ff + COUNT_W'(1);
                  idle_in  = 1'b0;
               end else begin
                  idle_in = 1'b1;
               end
               amp_in = cfg.decay_enable ? amp_scaled : '0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         amp_ff   <= '0;
         idle_ff  <= 1'b1;
      end else if (step) begin
         count_ff <= count_in;
         amp_ff   <= amp_in;
         idle_ff  <= idle_in;
      end
   end

   always_comb begin
      if (opcode == OP_TRIGGER) begin
         sample_out             = '0;
         flags.idle_flag        = idle_ff;
         flags.is_trigger_reply = 1'b1;
      end else begin
         sample_out             = vca_out;
         flags.idle_flag        = idle_in;
         flags.is_trigger_reply = 1'b0;
      end
   end

   a_trigger_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && opcode == OP_TRIGGER |=> count_ff == '0)
      else $error("count not cleared by a trigger");

   a_end_sets_idle: assert property (@(posedge clock) disable iff (reset)
      step && opcode == OP_SAMPLE && !in_rise && count_ff >= cfg.envelope_length
      |=> idle_ff && $stable(count_ff))
      else $error("envelope end did not hold count and set idle");

   a_trigger_keeps_idle: assert property (@(posedge clock) disable iff (reset)
      step && opcode == OP_TRIGGER |=> idle_ff == $past(idle_ff))
      else $error("trigger changed the idle state");

endmodule

[rtl/core/noise_burst_envelope_vca.sv]
// Noise burst envelope VCA, top level: input register, envelope unit and result register.
// A request beat passes the input register, then the result register. Throughput is
// one beat per cycle while rsp_stall is low; the envelope state updates as each item
// leaves the input register, so consecutive items see each other's updates.
// Reset clears both pipeline stages, the envelope state and sets every
// configuration register to its default.
module noise_burst_envelope_vca #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int AMP_FRAC_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [SAMPLE_WIDTH-1:0]          req_sample_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [SAMPLE_WIDTH-1:0]          rsp_sample_out,
   output logic                             rsp_idle_flag,
   output logic                             rsp_is_trigger_reply,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nbev_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nbev_pkg::CSR_DATA_W-1:0]  csr_data
);
   import nbev_pkg::*;

   nbev_cfg_type            cfg_ff, cfg_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_opcode_ff;
   logic [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_WIDTH-1:0] out_sample_ff;
   nbev_flags_type          out_flags_ff;
   logic                    advance;
   logic                    take;
   logic                    step;
   logic [SAMPLE_WIDTH-1:0] env_sample;
   nbev_flags_type          env_flags;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DECAY_ENABLE:        cfg_in.decay_enable        = csr_data[0];
            CSR_DECAY_COEF:          cfg_in.decay_coef          = csr_data[COEF_W-1:0];
            CSR_RISE_COEF:           cfg_in.rise_coef           = csr_data[COEF_W-1:0];
            CSR_RISE_LENGTH:         cfg_in.rise_length         = csr_data[COUNT_W-1:0];
            CSR_ENVELOPE_LENGTH:     cfg_in.envelope_length     = csr_data[COUNT_W-1:0];
            CSR_RETRIGGER_AMPLITUDE: cfg_in.retrigger_amplitude = csr_data[START_AMP_W-1:0];
            CSR_FRESH_AMPLITUDE:     cfg_in.fresh_amplitude     = csr_data[START_AMP_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_enable        <= 1'b0;
         cfg_ff.decay_coef          <= RST_DECAY_COEF;
         cfg_ff.rise_coef           <= RST_RISE_COEF;
         cfg_ff.rise_length         <= RST_RISE_LENGTH;
         cfg_ff.envelope_length     <= RST_ENVELOPE_LENGTH;
         cfg_ff.retrigger_amplitude <= RST_RETRIGGER_AMPLITUDE;
         cfg_ff.fresh_amplitude     <= RST_FRESH_AMPLITUDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance = !out_valid_ff || !rsp_stall;
   assign step    = s1_valid_ff && advance;
   assign take    = !s1_valid_ff || advance;
   assign req_stall = !take;

   always_comb begin
      s1_valid_in  = take ? req_valid : s1_valid_ff;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_valid) begin
         s1_opcode_ff <= req_opcode;
         s1_sample_ff <= req_sample_in;
      end
      if (step) begin
         out_sample_ff <= env_sample;
         out_flags_ff  <= env_flags;
      end
   end

   nbev_env #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .AMP_FRAC_BITS (AMP_FRAC_BITS)
   ) u_env (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (s1_opcode_ff),
      .sample_in  (s1_sample_ff),
      .cfg        (cfg_ff),
      .sample_out (env_sample),
      .flags      (env_flags)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_sample_out       = out_sample_ff;
   assign rsp_idle_flag        = out_flags_ff.idle_flag;
   assign rsp_is_trigger_reply = out_flags_ff.is_trigger_reply;

   a_trigger_reply_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_trigger_reply |-> rsp_sample_out == '0)
      else $error("trigger reply carries a non-zero sample");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("request stalled with room in the pipeline");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("stepped item did not reach the result register");

endmodule
